FILE: rtl/rtp_hdr_pkg.sv
// ----------------------------------------------------------------------------
// rtp header parser package
// widths, header masks and register map shared by the parser, its checker and testbench
// ----------------------------------------------------------------------------
package rtp_hdr_pkg;

  // longest packet accepted before the length check fails
  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned OFFSET_W = 17;
  localparam int unsigned LEN_W    = OFFSET_W + 1;
  // worst case header length: 12 + 4*15 + 4 + 4*65535 + 255
  localparam int unsigned NEED_W   = 19;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(MAX_PACKET_BYTES);

  // first header byte fields
  localparam logic [7:0] VERSION_MASK = 8'hC0;
  localparam logic [7:0] PADDING_MASK = 8'h20;
  localparam logic [7:0] EXT_MASK     = 8'h10;
  localparam logic [7:0] CC_MASK      = 8'h0F;
  // second header byte fields
  localparam logic [7:0] MARKER_MASK  = 8'h80;
  localparam logic [7:0] PT_MASK      = 8'h7F;

  localparam int unsigned FIXED_HDR_BYTES = 12;
  localparam int unsigned EXT_HDR_BYTES   = 4;

  // apb register map
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_REQUIRED_VERSION = 3'd0;
  localparam logic [1:0] VERSION_RESET = 2'd2;

endpackage

FILE: rtl/rtp_header_parser.sv
// ----------------------------------------------------------------------------
// rtp header parser
// byte-stream rtp header decoder with length and version checking
// ----------------------------------------------------------------------------
// a packet's result is registered in the cycle after its final byte is taken
// throughput: one byte per cycle while no result is held, packets may follow back to back
// a result waits in the output register; input stalls only while it is held
// reset (synchronous, rst high) clears the offset, captured header fields,
// overflow flag and output valid flag, and sets required_version to 2
// ----------------------------------------------------------------------------
module rtp_header_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rtp_hdr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rtp_hdr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rtp_hdr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                 pready,
  // byte request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           packet_byte,
  input  logic                                 last_byte,
  // result request channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 packet_valid,
  output logic                                 marker_bit,
  output logic [6:0]                           payload_type,
  output logic [3:0]                           csrc_count,
  output logic [15:0]                          sequence_number,
  output logic [31:0]                          time_stamp,
  output logic [31:0]                          sync_source,
  output logic                                 has_extension,
  output logic [15:0]                          extension_profile,
  output logic [15:0]                          extension_words,
  output logic [7:0]                           padding_bytes,
  output logic [15:0]                          payload_bytes
);
  import rtp_hdr_pkg::*;

  // configuration
  logic [1:0] required_version;
  logic       reg_sel;

  // packet state
  logic [OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic                length_overflow, length_overflow_next;
  logic [7:0]          hdr0, hdr0_next;
  logic [7:0]          hdr1, hdr1_next;
  logic [15:0]         seq, seq_next;
  logic [31:0]         ts, ts_next;
  logic [31:0]         ssrc, ssrc_next;
  logic [31:0]         ext, ext_next;

  // per-byte decode
  logic                accept;
  logic                in_range;
  logic                in_fixed_hdr;
  logic [6:0]          ext_start;
  logic [OFFSET_W-1:0] ext_diff;
  logic                in_ext_hdr;

  // result calculation
  logic                xflag, pflag;
  logic [3:0]          cc;
  logic [LEN_W-1:0]    pkt_len;
  logic [7:0]          pad;
  logic [NEED_W-1:0]   ext_total;
  logic [NEED_W-1:0]   base_len;
  logic [NEED_W-1:0]   need;
  logic [NEED_W-1:0]   len_wide;
  logic [NEED_W-1:0]   spare;
  logic                valid_calc;
  logic [15:0]         payload_calc;

  // --------------------------------------------------------------------------
  // apb register: word-aligned decode, a write lands in the access phase
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_REQUIRED_VERSION[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      required_version <= VERSION_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      required_version <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(APB_DATA_W-2){1'b0}}, required_version};
    end
  end

  // --------------------------------------------------------------------------
  // handshake: a new byte is taken whenever the result slot is free or
  // being drained in this cycle
  // --------------------------------------------------------------------------
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // capture: a byte at or past the maximum offset is dropped and flags
  // the packet as too long; otherwise it lands in the field that its
  // offset selects
  // --------------------------------------------------------------------------
  assign in_range     = (byte_offset < OFFSET_MAX);
  assign in_fixed_hdr = (byte_offset < OFFSET_W'(FIXED_HDR_BYTES));

  // extension header follows the csrc list; x flag comes from byte 0,
  // which is always captured before any extension byte arrives
  // (start reaches 72 with a full csrc list)
  assign ext_start  = 7'(FIXED_HDR_BYTES) + {1'b0, hdr0[3:0], 2'b00};
  assign ext_diff   = byte_offset - OFFSET_W'(ext_start);
  assign in_ext_hdr = ((hdr0 & EXT_MASK) != '0)
                      && (byte_offset >= OFFSET_W'(ext_start))
                      && (ext_diff < OFFSET_W'(EXT_HDR_BYTES));

  always_comb begin
    hdr0_next = hdr0;
    hdr1_next = hdr1;
    seq_next  = seq;
    ts_next   = ts;
    ssrc_next = ssrc;
    ext_next  = ext;
    length_overflow_next = length_overflow || !in_range;
    if (in_range && in_fixed_hdr) begin
      case (byte_offset[3:0])
        4'd0:    hdr0_next          = packet_byte;
        4'd1:    hdr1_next          = packet_byte;
        4'd2:    seq_next[15:8]     = packet_byte;
        4'd3:    seq_next[7:0]      = packet_byte;
        4'd4:    ts_next[31:24]     = packet_byte;
        4'd5:    ts_next[23:16]     = packet_byte;
        4'd6:    ts_next[15:8]      = packet_byte;
        4'd7:    ts_next[7:0]       = packet_byte;
        4'd8:    ssrc_next[31:24]   = packet_byte;
        4'd9:    ssrc_next[23:16]   = packet_byte;
        4'd10:   ssrc_next[15:8]    = packet_byte;
        4'd11:   ssrc_next[7:0]     = packet_byte;
        default: ;
      endcase
    end else if (in_range && in_ext_hdr) begin
      case (ext_diff[1:0])
        2'd0:    ext_next[31:24] = packet_byte;
        2'd1:    ext_next[23:16] = packet_byte;
        2'd2:    ext_next[15:8]  = packet_byte;
        default: ext_next[7:0]   = packet_byte;
      endcase
    end
    // offset holds once the maximum is reached
    byte_offset_next = in_range ? byte_offset + 1'b1 : byte_offset;
  end

  // --------------------------------------------------------------------------
  // result: lengths are checked against the header as it stands after
  // this byte, so the final byte itself may complete the header
  // --------------------------------------------------------------------------
  assign cc      = hdr0_next[3:0] & CC_MASK[3:0];
  assign xflag   = (hdr0_next & EXT_MASK) != '0;
  assign pflag   = (hdr0_next & PADDING_MASK) != '0;
  assign pkt_len = LEN_W'(byte_offset) + 1'b1;
  // padding count is the final byte taken as unsigned
  assign pad     = pflag ? packet_byte : 8'd0;

  assign base_len  = NEED_W'(FIXED_HDR_BYTES) + NEED_W'({cc, 2'b00});
  assign ext_total = xflag ? NEED_W'(EXT_HDR_BYTES) + NEED_W'({ext_next[15:0], 2'b00})
                           : '0;
  assign need      = base_len + ext_total + NEED_W'(pad);
  assign len_wide  = NEED_W'(pkt_len);
  assign spare     = len_wide - need;

  assign valid_calc = !length_overflow_next
                      && (((hdr0_next & VERSION_MASK) >> 6) == 8'(required_version))
                      && (len_wide >= NEED_W'(FIXED_HDR_BYTES))
                      && (!xflag || len_wide >= base_len + NEED_W'(EXT_HDR_BYTES))
                      && (len_wide >= need);

  // saturate the payload length to 16 bits
  assign payload_calc = !valid_calc                ? 16'd0 :
                        (spare > NEED_W'(16'hFFFF)) ? 16'hFFFF : spare[15:0];

  // --------------------------------------------------------------------------
  // packet state: cleared after every final byte
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      length_overflow <= 1'b0;
      hdr0            <= '0;
      hdr1            <= '0;
      seq             <= '0;
      ts              <= '0;
      ssrc            <= '0;
      ext             <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_offset     <= '0;
        length_overflow <= 1'b0;
        hdr0            <= '0;
        hdr1            <= '0;
        seq             <= '0;
        ts              <= '0;
        ssrc            <= '0;
        ext             <= '0;
      end else begin
        byte_offset     <= byte_offset_next;
        length_overflow <= length_overflow_next;
        hdr0            <= hdr0_next;
        hdr1            <= hdr1_next;
        seq             <= seq_next;
        ts              <= ts_next;
        ssrc            <= ssrc_next;
        ext             <= ext_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      packet_valid      <= valid_calc;
      marker_bit        <= (hdr1_next & MARKER_MASK) != '0;
      payload_type      <= hdr1_next[6:0] & PT_MASK[6:0];
      csrc_count        <= cc;
      sequence_number   <= seq_next;
      time_stamp        <= ts_next;
      sync_source       <= ssrc_next;
      has_extension     <= xflag;
      extension_profile <= xflag ? ext_next[31:16] : 16'd0;
      extension_words   <= xflag ? ext_next[15:0] : 16'd0;
      padding_bytes     <= pad;
      payload_bytes     <= payload_calc;
    end
  end

endmodule

FILE: dv/rtp_header_parser_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp header parser checker
// watches the config port and both request channels, decodes every accepted
// byte into the header it should produce, and compares each result with it
// ----------------------------------------------------------------------------
module rtp_header_parser_chk (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [rtp_hdr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rtp_hdr_pkg::APB_DATA_W-1:0]   pwdata,
  input  logic [rtp_hdr_pkg::APB_DATA_W-1:0]   prdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [7:0]                           packet_byte,
  input  logic                                 last_byte,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 packet_valid,
  input  logic                                 marker_bit,
  input  logic [6:0]                           payload_type,
  input  logic [3:0]                           csrc_count,
  input  logic [15:0]                          sequence_number,
  input  logic [31:0]                          time_stamp,
  input  logic [31:0]                          sync_source,
  input  logic                                 has_extension,
  input  logic [15:0]                          extension_profile,
  input  logic [15:0]                          extension_words,
  input  logic [7:0]                           padding_bytes,
  input  logic [15:0]                          payload_bytes,
  output int                                   mismatch_count,
  output int                                   headers_pending,
  output int                                   headers_checked
);
  import rtp_hdr_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        marker;
    logic [6:0]  pt;
    logic [3:0]  cc;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic        ext;
    logic [15:0] prof;
    logic [15:0] words;
    logic [7:0]  pad;
    logic [15:0] payload;
  } rtp_header_t;

  logic [1:0]  version_cfg;
  logic [16:0] byte_pos;
  logic        too_long;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [7:0]  fixed_bytes [0:9];
  logic [31:0] ext_hdr;
  rtp_header_t pending_headers [$];

  function automatic void clear_capture();
    byte_pos    = '0;
    too_long    = 1'b0;
    first_byte  = '0;
    second_byte = '0;
    ext_hdr     = '0;
    foreach (fixed_bytes[i]) fixed_bytes[i] = '0;
  endfunction

  // advance the capture by one byte, returns 1 with the header on a last byte
  function automatic bit decode_byte(input logic [7:0] b, input logic lst,
                                     output rtp_header_t hdr);
    int pos;
    int ext_start;
    int len;
    int need;
    int cc;
    bit ok;
    pos = byte_pos;
    hdr = '0;
    if (pos >= MAX_PACKET_BYTES) begin
      too_long = 1'b1;
    end else if (pos == 0) begin
      first_byte = b;
    end else if (pos == 1) begin
      second_byte = b;
    end else if (pos < FIXED_HDR_BYTES) begin
      fixed_bytes[pos-2] = b;
    end else begin
      ext_start = FIXED_HDR_BYTES + 4 * (first_byte & CC_MASK);
      if ((first_byte & EXT_MASK) != 0 && pos >= ext_start &&
          pos < ext_start + EXT_HDR_BYTES)
        ext_hdr[8*(3-(pos-ext_start)) +: 8] = b;
    end
    if (!lst) begin
      if (pos < MAX_PACKET_BYTES) byte_pos = pos + 1;
      return 1'b0;
    end
    len        = pos + 1;
    cc         = first_byte & CC_MASK;
    hdr.cc     = 4'(cc);
    hdr.ext    = (first_byte & EXT_MASK) != 0;
    hdr.marker = (second_byte & MARKER_MASK) != 0;
    hdr.pt     = 7'(second_byte & PT_MASK);
    hdr.seq    = {fixed_bytes[0], fixed_bytes[1]};
    hdr.ts     = {fixed_bytes[2], fixed_bytes[3], fixed_bytes[4], fixed_bytes[5]};
    hdr.ssrc   = {fixed_bytes[6], fixed_bytes[7], fixed_bytes[8], fixed_bytes[9]};
    if (hdr.ext) begin
      hdr.prof  = ext_hdr[31:16];
      hdr.words = ext_hdr[15:0];
    end
    // padding count is the last byte taken unsigned
    if ((first_byte & PADDING_MASK) != 0) hdr.pad = b;
    need = FIXED_HDR_BYTES + 4 * cc + int'(hdr.pad) +
           (hdr.ext ? EXT_HDR_BYTES + 4 * int'(hdr.words) : 0);
    ok = !too_long && ((first_byte & VERSION_MASK) >> 6) == version_cfg &&
         len >= FIXED_HDR_BYTES &&
         (!hdr.ext || len >= FIXED_HDR_BYTES + 4 * cc + EXT_HDR_BYTES) &&
         len >= need;
    hdr.ok = ok;
    if (ok) hdr.payload = (len - need > 65535) ? 16'hFFFF : 16'(len - need);
    clear_capture();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned seen);
    if (want != seen) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    rtp_header_t hdr;
    if (rst) begin
      clear_capture();
      version_cfg = VERSION_RESET;
      pending_headers.delete();
    end else begin
      if (psel && penable && pready && paddr == REG_REQUIRED_VERSION) begin
        if (pwrite) version_cfg = pwdata[1:0];
        else check_field("prdata", {30'b0, version_cfg}, prdata);
      end
      if (in_valid && in_ready) begin
        if (decode_byte(packet_byte, last_byte, hdr)) pending_headers.push_back(hdr);
      end
      if (out_valid && out_ready) begin
        if (pending_headers.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no packet pending", $time);
        end else begin
          hdr = pending_headers.pop_front();
          headers_checked++;
          check_field("packet_valid", hdr.ok, packet_valid);
          check_field("marker_bit", hdr.marker, marker_bit);
          check_field("payload_type", hdr.pt, payload_type);
          check_field("csrc_count", hdr.cc, csrc_count);
          check_field("sequence_number", hdr.seq, sequence_number);
          check_field("time_stamp", hdr.ts, time_stamp);
          check_field("sync_source", hdr.ssrc, sync_source);
          check_field("has_extension", hdr.ext, has_extension);
          check_field("extension_profile", hdr.prof, extension_profile);
          check_field("extension_words", hdr.words, extension_words);
          check_field("padding_bytes", hdr.pad, padding_bytes);
          check_field("payload_bytes", hdr.payload, payload_bytes);
        end
      end
    end
    headers_pending = pending_headers.size();
  end

endmodule

FILE: dv/rtp_header_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp header parser testbench
// streams rtp packets byte by byte into the parser: hand-built edge cases,
// over-length packets, then random well-formed, broken and noise packets
// under four version settings, mostly with random stalls on both channels
// ----------------------------------------------------------------------------
module rtp_header_parser_tb;
  import rtp_hdr_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            packet_byte;
  logic                  last_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  packet_valid;
  logic                  marker_bit;
  logic [6:0]            payload_type;
  logic [3:0]            csrc_count;
  logic [15:0]           sequence_number;
  logic [31:0]           time_stamp;
  logic [31:0]           sync_source;
  logic                  has_extension;
  logic [15:0]           extension_profile;
  logic [15:0]           extension_words;
  logic [7:0]            padding_bytes;
  logic [15:0]           payload_bytes;
  int                    mismatch_count;
  int                    headers_pending;
  int                    headers_checked;

  // random stalls on both channels while set
  bit       idle_on;
  // asks the result side for one long hold-off
  bit       hold_request;
  int       hold_left;
  int       bytes_sent;
  int       packets_sent;
  logic [7:0] pkt_bytes [$];

  rtp_header_parser dut (.*);
  rtp_header_parser_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous ceiling, the slowest correct run stays well under it
  initial begin
    #20_000_000;
    $display("timeout with %0d headers outstanding", headers_pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !idle_on || ($urandom_range(99) >= 17);
      end
    end
  end

  // one config access, setup then access phase, entered at a falling edge
  task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_REQUIRED_VERSION;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // offer one byte request and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic lst);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    packet_byte <= b;
    last_byte   <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  // stop offering and let every pending header come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (headers_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // lay out a packet: fixed header, csrc list, extension, payload, padding
  task automatic make_packet(input logic [1:0] ver, input bit pad, input bit ext,
                             input logic [3:0] cc, input bit mk, input logic [6:0] pt,
                             input logic [15:0] seq, input logic [31:0] ts,
                             input logic [31:0] ssrc, input logic [15:0] prof,
                             input logic [15:0] words, input int body_words,
                             input int payload_len, input int pad_len);
    pkt_bytes.delete();
    pkt_bytes.push_back({ver, pad, ext, cc});
    pkt_bytes.push_back({mk, pt});
    pkt_bytes.push_back(seq[15:8]);
    pkt_bytes.push_back(seq[7:0]);
    for (int i = 3; i >= 0; i--) pkt_bytes.push_back(ts[8*i +: 8]);
    for (int i = 3; i >= 0; i--) pkt_bytes.push_back(ssrc[8*i +: 8]);
    repeat (4 * cc) pkt_bytes.push_back(8'($urandom));
    if (ext) begin
      pkt_bytes.push_back(prof[15:8]);
      pkt_bytes.push_back(prof[7:0]);
      pkt_bytes.push_back(words[15:8]);
      pkt_bytes.push_back(words[7:0]);
      repeat (4 * body_words) pkt_bytes.push_back(8'($urandom));
    end
    repeat (payload_len) pkt_bytes.push_back(8'($urandom));
    // the pad count always rides in the final byte
    if (pad) begin
      repeat (pad_len - 1) pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'(pad_len));
    end
  endtask

  // mostly well-formed packets, some with a wrong version, bad padding,
  // truncation or plain noise
  task automatic random_packet(input logic [1:0] want_ver);
    int kind;
    int n;
    int cc;
    int words;
    int body;
    int pad_len;
    logic [1:0] ver;
    kind    = $urandom_range(99);
    cc      = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2);
    words   = $urandom_range(3);
    body    = ($urandom_range(9) == 0) ? $urandom_range(3) : words;
    pad_len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(6);
    ver     = want_ver;
    if (kind >= 70 && kind < 80) ver = want_ver + 2'($urandom_range(1, 3));
    make_packet(ver, 1'($urandom), 1'($urandom), 4'(cc), 1'($urandom),
                7'($urandom), 16'($urandom), $urandom, $urandom, 16'($urandom),
                16'(words), body, $urandom_range(20), pad_len);
    if (kind >= 65 && kind < 70) begin
      // pad count that need not match the packet
      pkt_bytes[pkt_bytes.size()-1] = 8'($urandom);
    end else if (kind >= 80 && kind < 90) begin
      n = $urandom_range(1, pkt_bytes.size());
      pkt_bytes = pkt_bytes[0:n-1];
    end else if (kind >= 90) begin
      pkt_bytes.delete();
      repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom));
    end
    send_packet();
  endtask

  initial begin
    logic [1:0] sweep [4];
    int phase_end;
    int in_phase;
    int guard;
    sweep        = '{2'd0, 2'd3, 2'd1, 2'd2};
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    packet_byte  = '0;
    last_byte    = 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    bytes_sent   = 0;
    packets_sent = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // version register should come up as 2
    apb_access(1'b0, '0);

    // minimal header, every field zero but the version
    make_packet(2'd2, 0, 0, 4'd0, 0, 7'd0, 16'h0, 32'h0, 32'h0, 16'h0, 16'h0, 0, 0, 0);
    send_packet();
    // most header fields at their top value, full csrc list and a one-word extension
    make_packet(2'd2, 0, 1, 4'd15, 1, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                16'hFFFF, 16'h0001, 1, 3, 0);
    send_packet();
    // largest pad count, above 127 so a signed read would go wrong
    make_packet(2'd2, 1, 0, 4'd0, 0, 7'd96, 16'h1234, 32'h89AB_CDEF, 32'h0102_0304,
                16'h0, 16'h0, 0, 4, 255);
    send_packet();
    // pad flag with a zero pad count
    make_packet(2'd2, 1, 1, 4'd2, 1, 7'd33, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF,
                16'hBEDE, 16'h0000, 0, 5, 0);
    send_packet();
    // pad count larger than the whole packet
    make_packet(2'd2, 1, 0, 4'd1, 0, 7'd8, 16'h0042, 32'h0, 32'h5555_AAAA,
                16'h0, 16'h0, 0, 0, 1);
    pkt_bytes[pkt_bytes.size()-1] = 8'hC8;
    send_packet();
    // wrong version
    make_packet(2'd3, 0, 0, 4'd0, 0, 7'd0, 16'h1, 32'h2, 32'h3, 16'h0, 16'h0, 0, 8, 0);
    send_packet();
    // short packets: a single byte and one byte shy of the fixed header
    pkt_bytes = '{8'hFF};
    send_packet();
    make_packet(2'd2, 0, 0, 4'd0, 1, 7'd5, 16'hA5A5, 32'h5A5A_5A5A, 32'hC3C3_C3C3,
                16'h0, 16'h0, 0, 0, 0);
    pkt_bytes = pkt_bytes[0:10];
    send_packet();
    // extension that claims far more words than arrive
    make_packet(2'd2, 0, 1, 4'd0, 0, 7'd1, 16'h7, 32'h7, 32'h7, 16'h1000, 16'hFFFF,
                0, 6, 0);
    send_packet();
    // cut in the middle of the extension header
    make_packet(2'd2, 0, 1, 4'd1, 0, 7'd2, 16'h9, 32'h9, 32'h9, 16'hABCD, 16'h0002,
                2, 0, 0);
    pkt_bytes = pkt_bytes[0:17];
    send_packet();

    // longest packet still accepted, then one five bytes past the limit
    idle_on = 1'b0;
    make_packet(2'd2, 0, 0, 4'd0, 0, 7'd11, 16'h1111, 32'h2222_2222, 32'h3333_3333,
                16'h0, 16'h0, 0, MAX_PACKET_BYTES - FIXED_HDR_BYTES, 0);
    send_packet();
    make_packet(2'd2, 0, 0, 4'd0, 1, 7'd12, 16'h4444, 32'h5555_5555, 32'h6666_6666,
                16'h0, 16'h0, 0, MAX_PACKET_BYTES - FIXED_HDR_BYTES + 5, 0);
    send_packet();

    // random packets under each version setting, extremes included
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      apb_access(1'b1, {30'($urandom), sweep[phase]});
      apb_access(1'b0, '0);
      // third setting runs with no stalls at all
      idle_on   = (phase != 2);
      phase_end = bytes_sent + 365;
      in_phase  = 0;
      while (bytes_sent < phase_end) begin
        // long result hold-off while short packets keep coming
        if (phase == 0 && in_phase == 6) hold_request = 1'b1;
        random_packet(sweep[phase]);
        in_phase++;
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    while (headers_pending != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);

    $display("sent %0d bytes in %0d packets, %0d headers checked", bytes_sent,
             packets_sent, headers_checked);
    $display("versions 2,0,3,1,2; short, over-length, padded, extended and noise packets");
    if (mismatch_count == 0 && headers_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d headers never came out", mismatch_count,
               headers_pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rtp_hdr_pkg.sv
rtl/rtp_header_parser.sv
dv/rtp_header_parser_chk.sv
dv/rtp_header_parser_tb.sv
